// ===== src/ngr_pkg.sv =====
package ngr_pkg;

    localparam logic [31:0] ACC_CAP     = 32'd4000000000;
    localparam logic [31:0] LAT_MAX     = 32'd900000000;
    localparam logic [31:0] LON_MAX     = 32'd1800000000;
    localparam logic [31:0] ALT_POS_MAX = 32'd999999;
    localparam logic [31:0] ALT_NEG_MAX = 32'd99999;
    localparam logic [31:0] HDOP_MAX    = 32'd9999;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_N      = 8'h4E;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_W      = 8'h57;

    localparam logic [1:0] HM_GGA = 2'b01;
    localparam logic [1:0] HM_RMC = 2'b10;

    typedef struct packed {
        logic tm;
        logic lat;
        logic lon;
        logic alt;
        logic hdop;
    } mask_t;

    typedef struct packed {
        logic        rmc;
        logic        status;
        mask_t       mask;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic [3:0]  fix;
        logic [6:0]  sats;
        logic [31:0] lat_acc;
        logic [2:0]  lat_fd;
        logic        lat_neg;
        logic [31:0] lon_acc;
        logic [2:0]  lon_fd;
        logic        lon_neg;
        logic [31:0] alt_acc;
        logic [2:0]  alt_fd;
        logic        alt_neg;
        logic [31:0] hdop_acc;
        logic [2:0]  hdop_fd;
    } entry_t;

    // a*10+d, saturating at the accumulator cap
    function automatic logic [31:0] mul10_sat(logic [31:0] a, logic [3:0] d);
        logic [35:0] v;
        v = ({4'd0, a} << 3) + ({4'd0, a} << 1) + {32'd0, d};
        return (v > {4'd0, ACC_CAP}) ? ACC_CAP : v[31:0];
    endfunction

endpackage

// ===== src/ngr_queue.sv =====
module ngr_queue
    import ngr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t wdata,
    output logic   full,
    input  logic   pop,
    output logic   not_empty,
    output entry_t rdata,
    output logic [1:0] count
);

    entry_t     mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign rdata     = mem_reg[rd_ptr_reg];
    assign count     = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

// ===== src/ngr_front.sv =====
module ngr_front
    import ngr_pkg::*;
#(
    parameter int LINE_MAX = 128
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] rx_byte,
    output logic       push,
    output entry_t     entry
);

    localparam int CW = $clog2(LINE_MAX);

    typedef enum logic [3:0] {
        K_NONE, K_TIME, K_LAT, K_NS, K_LON, K_EW, K_FIX, K_SATS, K_HDOP, K_ALT, K_STATUS
    } kind_t;

    logic          in_sent_reg, in_sent_next;
    logic [CW-1:0] cc_reg, cc_next;
    logic [4:0]    fnum_reg, fnum_next;
    logic [1:0]    hm_reg, hm_next;
    logic [31:0]   acc_reg, acc_next;
    logic [2:0]    fd_reg, fd_next;
    logic [1:0]    phase_reg, phase_next;
    logic          neg_reg, neg_next;
    logic [7:0]    first_reg, first_next;
    logic [2:0]    fpos_reg, fpos_next;
    entry_t        st_reg, st_next;
    logic          push_next;

    function automatic kind_t field_kind(logic [4:0] fn, logic [1:0] hm, logic st);
        kind_t k;
        k = K_NONE;
        if (hm == HM_GGA)
        begin
            case (fn)
                5'd1: k = K_TIME;
                5'd2: k = K_LAT;
                5'd3: k = K_NS;
                5'd4: k = K_LON;
                5'd5: k = K_EW;
                5'd6: k = K_FIX;
                5'd7: k = K_SATS;
                5'd8: k = K_HDOP;
                5'd9: k = K_ALT;
                default: k = K_NONE;
            endcase
        end
        else if (hm == HM_RMC)
        begin
            case (fn)
                5'd1: k = K_TIME;
                5'd2: k = K_STATUS;
                5'd3: k = st ? K_LAT : K_NONE;
                5'd4: k = K_NS;
                5'd5: k = st ? K_LON : K_NONE;
                5'd6: k = K_EW;
                default: k = K_NONE;
            endcase
        end
        return k;
    endfunction

    always_comb
    begin
        logic [7:0]    c;
        logic          is_dig;
        logic [3:0]    dval;
        kind_t         k;
        logic          ok;
        logic [2:0]    pos;
        logic [CW-1:0] cpos;
        logic [2:0]    fmax;
        logic [1:0]    ph;
        logic          skip;

        c      = rx_byte;
        is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
        dval   = c[3:0];
        k      = field_kind(fnum_reg, hm_reg, st_reg.status);
        ok     = (fpos_reg != 3'd0) && (first_reg >= CH_ZERO);
        pos    = fpos_reg;
        cpos   = cc_reg;
        fmax   = 3'd0;
        ph     = phase_reg;
        skip   = 1'b0;

        in_sent_next = in_sent_reg;
        cc_next      = cc_reg;
        fnum_next    = fnum_reg;
        hm_next      = hm_reg;
        acc_next     = acc_reg;
        fd_next      = fd_reg;
        phase_next   = phase_reg;
        neg_next     = neg_reg;
        first_next   = first_reg;
        fpos_next    = fpos_reg;
        st_next      = st_reg;
        push_next    = 1'b0;

        if (c == CH_DOLLAR)
        begin
            in_sent_next = 1'b1;
            cc_next      = CW'(1);
            fnum_next    = 5'd0;
            hm_next      = HM_GGA | HM_RMC;
            st_next      = '0;
            acc_next     = 32'd0;
            fd_next      = 3'd0;
            phase_next   = 2'd0;
            neg_next     = 1'b0;
            first_next   = 8'd0;
            fpos_next    = 3'd0;
        end
        else if (in_sent_reg)
        begin
            if (c == CH_CR || c == CH_LF || c == CH_COMMA)
            begin
                // close the current field
                case (k)
                    K_TIME:
                        if (ok)
                            st_next.mask.tm = 1'b1;
                    K_LAT:
                        if (ok)
                        begin
                            st_next.lat_acc  = acc_reg;
                            st_next.lat_fd   = fd_reg;
                            st_next.mask.lat = 1'b1;
                        end
                    K_LON:
                        if (ok)
                        begin
                            st_next.lon_acc  = acc_reg;
                            st_next.lon_fd   = fd_reg;
                            st_next.mask.lon = 1'b1;
                        end
                    K_HDOP:
                        if (ok)
                        begin
                            st_next.hdop_acc  = acc_reg;
                            st_next.hdop_fd   = fd_reg;
                            st_next.mask.hdop = 1'b1;
                        end
                    K_ALT:
                        if (fpos_reg != 3'd0 && (ok || first_reg == CH_MINUS))
                        begin
                            st_next.alt_acc  = acc_reg;
                            st_next.alt_fd   = fd_reg;
                            st_next.alt_neg  = neg_reg;
                            st_next.mask.alt = 1'b1;
                        end
                    default: ;
                endcase
            end

            if (c == CH_CR || c == CH_LF)
            begin
                in_sent_next = 1'b0;
                if (cc_reg > CW'(6) && (hm_reg == HM_GGA || hm_reg == HM_RMC))
                begin
                    push_next   = 1'b1;
                    st_next.rmc = (hm_reg == HM_RMC);
                end
            end
            else if (cc_reg >= CW'(LINE_MAX - 1))
            begin
                in_sent_next = 1'b0;
            end
            else
            begin
                cc_next = cc_reg + CW'(1);
                case (cpos)
                    CW'(1):
                        if (c != CH_G) hm_next = 2'b00;
                    CW'(2):
                        if (c != CH_P && c != CH_N) hm_next = 2'b00;
                    CW'(3):
                    begin
                        if (c != CH_G) hm_next[0] = 1'b0;
                        if (c != CH_R) hm_next[1] = 1'b0;
                    end
                    CW'(4):
                    begin
                        if (c != CH_G) hm_next[0] = 1'b0;
                        if (c != CH_M) hm_next[1] = 1'b0;
                    end
                    CW'(5):
                    begin
                        if (c != CH_A) hm_next[0] = 1'b0;
                        if (c != CH_C) hm_next[1] = 1'b0;
                    end
                    default: ;
                endcase

                if (c == CH_COMMA)
                begin
                    if (fnum_reg != 5'd31)
                        fnum_next = fnum_reg + 5'd1;
                    acc_next   = 32'd0;
                    fd_next    = 3'd0;
                    phase_next = 2'd0;
                    neg_next   = 1'b0;
                    first_next = 8'd0;
                    fpos_next  = 3'd0;
                end
                else
                begin
                    if (fpos_reg != 3'd7)
                        fpos_next = fpos_reg + 3'd1;
                    if (pos == 3'd0)
                        first_next = c;
                    case (k)
                        K_TIME, K_SATS:
                            if ((k == K_TIME && pos < 3'd6) || (k == K_SATS && pos < 3'd2))
                            begin
                                // two-digit pair scan
                                if (!pos[0])
                                begin
                                    acc_next   = is_dig ? {28'd0, dval} : 32'd0;
                                    phase_next = is_dig ? 2'd1 : 2'd3;
                                end
                                else if (phase_reg == 2'd1 && is_dig)
                                    acc_next = mul10_sat(acc_reg, dval);
                                else
                                    phase_next = 2'd3;
                                if (k == K_SATS)
                                    st_next.sats = acc_next[6:0];
                                else if (pos[2:1] == 2'd0)
                                    st_next.hour = acc_next[6:0];
                                else if (pos[2:1] == 2'd1)
                                    st_next.minute = acc_next[6:0];
                                else
                                    st_next.second = acc_next[6:0];
                            end
                        K_FIX:
                            if (pos == 3'd0)
                                st_next.fix = is_dig ? dval : 4'd0;
                        K_STATUS:
                            if (pos == 3'd0)
                                st_next.status = (c == CH_A);
                        K_NS:
                            if (pos == 3'd0 && c == CH_S && st_reg.mask.lat)
                                st_next.lat_neg = ~st_reg.lat_neg;
                        K_EW:
                            if (pos == 3'd0 && c == CH_W && st_reg.mask.lon)
                                st_next.lon_neg = ~st_reg.lon_neg;
                        K_LAT, K_LON, K_ALT, K_HDOP:
                        begin
                            fmax = (k == K_ALT) ? 3'd1 : (k == K_HDOP) ? 3'd2 : 3'd5;
                            if (ph == 2'd0)
                            begin
                                ph = 2'd1;
                                phase_next = 2'd1;
                                if (c == CH_MINUS)
                                begin
                                    neg_next = 1'b1;
                                    skip     = 1'b1;
                                end
                            end
                            if (!skip)
                            begin
                                if (ph == 2'd1)
                                begin
                                    if (is_dig)
                                        acc_next = mul10_sat(acc_reg, dval);
                                    else if (c == CH_DOT)
                                        phase_next = 2'd2;
                                    else
                                        phase_next = 2'd3;
                                end
                                else if (ph == 2'd2)
                                begin
                                    if (is_dig)
                                    begin
                                        if (fd_reg < fmax)
                                        begin
                                            acc_next = mul10_sat(acc_reg, dval);
                                            fd_next  = fd_reg + 3'd1;
                                        end
                                    end
                                    else
                                        phase_next = 2'd3;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    assign push  = accept && push_next;
    assign entry = st_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_sent_reg <= 1'b0;
            cc_reg      <= '0;
            fnum_reg    <= 5'd0;
            hm_reg      <= 2'b00;
            acc_reg     <= 32'd0;
            fd_reg      <= 3'd0;
            phase_reg   <= 2'd0;
            neg_reg     <= 1'b0;
            first_reg   <= 8'd0;
            fpos_reg    <= 3'd0;
            st_reg      <= '0;
        end
        else if (accept)
        begin
            in_sent_reg <= in_sent_next;
            cc_reg      <= cc_next;
            fnum_reg    <= fnum_next;
            hm_reg      <= hm_next;
            acc_reg     <= acc_next;
            fd_reg      <= fd_next;
            phase_reg   <= phase_next;
            neg_reg     <= neg_next;
            first_reg   <= first_next;
            fpos_reg    <= fpos_next;
            st_reg      <= st_next;
        end
    end

endmodule

// ===== src/ngr_deg.sv =====
module ngr_deg
    import ngr_pkg::*;
#(
    parameter logic [31:0] LIMIT = 32'd900000000
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] acc,
    input  logic [2:0]  fd,
    output logic        done,
    output logic [31:0] result
);

    // floor(x/1e7) = (x*M10)>>56 for 32-bit x, floor(y/3) = (y*M3)>>28 for 26-bit y
    localparam logic [32:0] M10 = 33'd7205759404;
    localparam logic [26:0] M3  = 27'd89478486;
    localparam logic [31:0] E7  = 32'd10000000;

    logic [3:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [2:0]  fd_reg;
    logic [31:0] s_reg;
    logic [64:0] prod_reg;
    logic [31:0] qe_reg;
    logic [25:0] rem5_reg;
    logic [52:0] p3_reg;
    logic [31:0] res_reg;

    logic [8:0]  q;
    logic [31:0] qe;
    logic [23:0] rem;
    logic [32:0] e7;

    assign q   = prod_reg[64:56];
    assign qe  = 32'({q} * E7);
    assign rem = 24'(s_reg - qe);
    assign e7  = {1'b0, qe_reg} + {8'd0, p3_reg[52:28]};

    assign done   = done_reg;
    assign result = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 4'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 4'd0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 4'd1;
                if (step_reg == 4'd8)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            s_reg  <= acc;
            fd_reg <= fd;
        end
        else if (busy_reg)
        begin
            // five scaling steps bring the value to 5 fraction digits
            if (step_reg < 4'd5)
            begin
                if (step_reg[2:0] >= fd_reg)
                    s_reg <= mul10_sat(s_reg, 4'd0);
            end
            else if (step_reg == 4'd5)
                prod_reg <= {33'd0, s_reg} * {32'd0, M10};
            else if (step_reg == 4'd6)
            begin
                qe_reg   <= qe;
                rem5_reg <= {2'b00, rem} + {rem, 2'b00};
            end
            else if (step_reg == 4'd7)
                p3_reg <= {27'd0, rem5_reg} * {26'd0, M3};
            else
                res_reg <= (e7 > {1'b0, LIMIT}) ? LIMIT : e7[31:0];
        end
    end

endmodule

// ===== src/ngr_back.sv =====
module ngr_back
    import ngr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  entry_t      q_data,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        sentence_type,
    output logic [6:0]  utc_hour,
    output logic [6:0]  utc_minute,
    output logic [6:0]  utc_second,
    output logic signed [30:0] latitude_e7,
    output logic signed [31:0] longitude_e7,
    output logic [3:0]  fix_code,
    output logic [6:0]  satellites,
    output logic signed [20:0] altitude_dm,
    output logic [13:0] hdop_centi,
    output logic        lat_done,
    output logic        lon_done
);

    typedef enum logic [1:0] {S_IDLE, S_CONV, S_COMMIT} state_t;

    state_t      state_reg;
    entry_t      cur_reg;
    logic [2:0]  cnt_reg;
    logic [31:0] alt_s_reg, hdop_s_reg;
    logic        out_valid_reg;
    logic        type_reg;
    logic [6:0]  hour_reg, minute_reg, second_reg, sats_reg;
    logic [30:0] lat_reg;
    logic [31:0] lon_reg;
    logic [3:0]  fix_reg;
    logic [20:0] alt_reg;
    logic [13:0] hdop_reg;

    logic [31:0] lat_mag, lon_mag, alt_mag;
    logic        commit;

    assign pop    = (state_reg == S_IDLE) && q_valid;
    assign commit = (state_reg == S_COMMIT) && (!out_valid_reg || out_ready);

    ngr_deg #(.LIMIT(LAT_MAX)) u_lat (
        .clk(clk), .rst_n(rst_n), .start(pop),
        .acc(q_data.lat_acc), .fd(q_data.lat_fd),
        .done(lat_done), .result(lat_mag)
    );

    ngr_deg #(.LIMIT(LON_MAX)) u_lon (
        .clk(clk), .rst_n(rst_n), .start(pop),
        .acc(q_data.lon_acc), .fd(q_data.lon_fd),
        .done(lon_done), .result(lon_mag)
    );

    always_comb
    begin
        if (cur_reg.alt_neg)
            alt_mag = (alt_s_reg > ALT_NEG_MAX) ? ALT_NEG_MAX : alt_s_reg;
        else
            alt_mag = (alt_s_reg > ALT_POS_MAX) ? ALT_POS_MAX : alt_s_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            type_reg      <= 1'b0;
            hour_reg      <= 7'd0;
            minute_reg    <= 7'd0;
            second_reg    <= 7'd0;
            lat_reg       <= 31'd0;
            lon_reg       <= 32'd0;
            fix_reg       <= 4'd0;
            sats_reg      <= 7'd0;
            alt_reg       <= 21'd0;
            hdop_reg      <= 14'd0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (q_valid)
                        state_reg <= S_CONV;
                S_CONV:
                    if (lat_done)
                        state_reg <= S_COMMIT;
                S_COMMIT:
                    if (commit)
                    begin
                        state_reg     <= S_IDLE;
                        out_valid_reg <= 1'b1;
                        type_reg      <= cur_reg.rmc;
                        if (cur_reg.mask.tm)
                        begin
                            hour_reg   <= cur_reg.hour;
                            minute_reg <= cur_reg.minute;
                            second_reg <= cur_reg.second;
                        end
                        if (!cur_reg.rmc || cur_reg.status)
                        begin
                            if (cur_reg.mask.lat)
                                lat_reg <= cur_reg.lat_neg ? 31'(-lat_mag) : lat_mag[30:0];
                            if (cur_reg.mask.lon)
                                lon_reg <= cur_reg.lon_neg ? (32'd0 - lon_mag) : lon_mag;
                        end
                        if (cur_reg.rmc)
                        begin
                            if (!cur_reg.status)
                                fix_reg <= 4'd0;
                            else if (fix_reg == 4'd0)
                                fix_reg <= 4'd1;
                        end
                        else
                        begin
                            fix_reg  <= cur_reg.fix;
                            sats_reg <= cur_reg.sats;
                            if (cur_reg.mask.alt)
                                alt_reg <= cur_reg.alt_neg ? 21'(-alt_mag) : alt_mag[20:0];
                            if (cur_reg.mask.hdop)
                                hdop_reg <= (hdop_s_reg > HDOP_MAX) ? HDOP_MAX[13:0]
                                                                    : hdop_s_reg[13:0];
                        end
                    end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // altitude and hdop scaling runs beside the degree units
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg    <= q_data;
            cnt_reg    <= 3'd0;
            alt_s_reg  <= q_data.alt_acc;
            hdop_s_reg <= q_data.hdop_acc;
        end
        else if (state_reg == S_CONV && cnt_reg < 3'd2)
        begin
            cnt_reg <= cnt_reg + 3'd1;
            if (cnt_reg >= cur_reg.alt_fd && cnt_reg < 3'd1)
                alt_s_reg <= mul10_sat(alt_s_reg, 4'd0);
            if (cnt_reg >= cur_reg.hdop_fd)
                hdop_s_reg <= mul10_sat(hdop_s_reg, 4'd0);
        end
    end

    assign out_valid     = out_valid_reg;
    assign sentence_type = type_reg;
    assign utc_hour      = hour_reg;
    assign utc_minute    = minute_reg;
    assign utc_second    = second_reg;
    assign latitude_e7   = lat_reg;
    assign longitude_e7  = lon_reg;
    assign fix_code      = fix_reg;
    assign satellites    = sats_reg;
    assign altitude_dm   = alt_reg;
    assign hdop_centi    = hdop_reg;

endmodule

// ===== src/nmea_gga_rmc_sentence_parser.sv =====
// nmea gga / rmc sentence parser
// input channel: rx_byte with in_valid / in_ready, one received character per item.
// output channel: one position record per item with out_valid / out_ready; it is
// emitted for every gga or rmc sentence that ends in cr or lf within LINE_MAX
// characters and after more than six stored characters.
// the byte front end takes one byte per cycle; in_ready drops only when the
// two-entry sentence queue is full.
// the record engine handles one sentence at a time: a pop, 5 scaling steps
// and 4 multiply / remainder steps in the degree converters, a check that
// they are done, then a commit.
// a stalled output holds the record; the engine finishes the next sentence and
// waits to commit, while the front end keeps taking bytes until the queue fills.
// reset clears the record to zero and drops any sentence in progress.
module nmea_gga_rmc_sentence_parser
    import ngr_pkg::*;
#(
    parameter int LINE_MAX = 128
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        sentence_type,
    output logic [6:0]  utc_hour,
    output logic [6:0]  utc_minute,
    output logic [6:0]  utc_second,
    output logic signed [30:0] latitude_e7,
    output logic signed [31:0] longitude_e7,
    output logic [3:0]  fix_code,
    output logic [6:0]  satellites,
    output logic signed [20:0] altitude_dm,
    output logic [13:0] hdop_centi
);

    logic       push, full, pop, q_valid;
    entry_t     wdata, rdata;
    logic [1:0] q_count;
    logic       lat_done, lon_done;

    assign in_ready = !full;

    ngr_front #(.LINE_MAX(LINE_MAX)) u_front (
        .clk(clk), .rst_n(rst_n), .accept(in_valid && in_ready),
        .rx_byte(rx_byte), .push(push), .entry(wdata)
    );

    ngr_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .wdata(wdata), .full(full),
        .pop(pop), .not_empty(q_valid), .rdata(rdata), .count(q_count)
    );

    ngr_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_data(rdata), .pop(pop),
        .out_valid(out_valid), .out_ready(out_ready),
        .sentence_type(sentence_type), .utc_hour(utc_hour), .utc_minute(utc_minute),
        .utc_second(utc_second), .latitude_e7(latitude_e7), .longitude_e7(longitude_e7),
        .fix_code(fix_code), .satellites(satellites), .altitude_dm(altitude_dm),
        .hdop_centi(hdop_centi), .lat_done(lat_done), .lon_done(lon_done)
    );

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count != 2'd3)
        else $error("sentence queue over capacity");

    a_conv_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        lat_done == lon_done)
        else $error("degree converters out of step");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue push while full");

    a_out_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(pop))
        else $error("record emitted without conversion time");

endmodule
